### hdl/mpv_pkg.sv
// mpv_pkg: shared types, constants and lookup functions for the managed path validator
// no dependencies
`default_nettype none

package mpv_pkg;

  localparam int unsigned PREFIX_LEN = 10;

  localparam logic [2:0] PH_ROOT       = 3'd0;
  localparam logic [2:0] PH_AFTER_ROOT = 3'd1;
  localparam logic [2:0] PH_NAME       = 3'd2;
  localparam logic [2:0] PH_SEGMENT    = 3'd3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic       fire;
    logic [7:0] code;
  } mpv_step_t;

  function automatic logic [7:0] root_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h2F;
      4'd1:    b = 8'h46;
      4'd2:    b = 8'h69;
      4'd3:    b = 8'h72;
      4'd4:    b = 8'h65;
      4'd5:    b = 8'h66;
      4'd6:    b = 8'h6C;
      4'd7:    b = 8'h79;
      4'd8:    b = 8'h4F;
      4'd9:    b = 8'h53;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [3:0] name_len(input logic [3:0] name);
    logic [3:0] n;
    case (name)
      4'd0:    n = 4'd5;
      4'd1:    n = 4'd10;
      4'd2:    n = 4'd8;
      4'd3:    n = 4'd6;
      4'd4:    n = 4'd7;
      4'd5:    n = 4'd7;
      4'd6:    n = 4'd4;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  // strings are right-justified, first character at the top
  function automatic logic [7:0] name_char(input logic [3:0] name, input logic [3:0] pos);
    logic [127:0] s;
    logic [3:0]   n;
    logic [3:0]   k;
    n = name_len(name);
    case (name)
      4'd0:    s = 128'("Music");
      4'd1:    s = 128'("Recordings");
      4'd2:    s = 128'("Pictures");
      4'd3:    s = 128'("Themes");
      4'd4:    s = 128'("Updates");
      4'd5:    s = 128'("Backups");
      4'd6:    s = 128'("Logs");
      default: s = '0;
    endcase
    k = n - 4'd1 - pos;
    if (pos < n) begin
      return s[{k, 3'b000} +: 8];
    end
    return 8'h00;
  endfunction

endpackage

`default_nettype wire

### hdl/mpv_core.sv
// mpv_core: path state registers and the per-byte check logic
// depends on mpv_pkg
`default_nettype none

module mpv_core
  import mpv_pkg::*;
#(
  parameter int unsigned NAME_COUNT = 7
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire mpv_step_t step,
  output logic           verdict
);

  logic [2:0]            phase_r, phase_nxt;
  logic [3:0]            prefix_pos_r, prefix_pos_nxt;
  logic [NAME_COUNT-1:0] cand_r, cand_nxt;
  logic [3:0]            name_pos_r, name_pos_nxt;
  logic [1:0]            seg_len_r, seg_len_nxt;
  logic                  seg_dots_r, seg_dots_nxt;
  logic                  rej_r, rej_nxt;

  logic [NAME_COUNT-1:0] len_hit;
  logic [NAME_COUNT-1:0] char_hit;
  logic                  name_done;
  logic [3:0]            prefix_inc;
  logic                  dot_seg;
  logic [7:0]            c;

  assign c = step.code;

  always_comb begin
    for (int i = 0; i < NAME_COUNT; i++) begin
      len_hit[i]  = (name_len(4'(i)) == name_pos_r);
      char_hit[i] = (name_pos_r < name_len(4'(i))) && (name_char(4'(i), name_pos_r) == c);
    end
  end

  assign name_done  = |(cand_r & len_hit);
  assign prefix_inc = prefix_pos_r + 4'd1;
  assign dot_seg    = ((seg_len_r == 2'd1) || (seg_len_r == 2'd2)) && seg_dots_r;

  always_comb begin
    if (rej_r) begin
      verdict = 1'b0;
    end else begin
      case (phase_r)
        PH_AFTER_ROOT: verdict = 1'b1;
        PH_NAME:       verdict = (name_pos_r == 4'd0) || name_done;
        PH_SEGMENT:    verdict = !dot_seg;
        default:       verdict = 1'b0;
      endcase
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    prefix_pos_nxt = prefix_pos_r;
    cand_nxt       = cand_r;
    name_pos_nxt   = name_pos_r;
    seg_len_nxt    = seg_len_r;
    seg_dots_nxt   = seg_dots_r;
    rej_nxt        = rej_r;
    if (c == CH_NUL) begin
      phase_nxt      = PH_ROOT;
      prefix_pos_nxt = '0;
      cand_nxt       = '1;
      name_pos_nxt   = '0;
      seg_len_nxt    = '0;
      seg_dots_nxt   = 1'b1;
      rej_nxt        = 1'b0;
    end else if (!rej_r) begin
      case (phase_r)
        PH_ROOT: begin
          if (c != root_byte(prefix_pos_r)) begin
            rej_nxt = 1'b1;
          end else begin
            prefix_pos_nxt = prefix_inc;
            if (({1'b0, prefix_inc} >= 5'(PREFIX_LEN)) || (prefix_inc == 4'd0)) begin
              phase_nxt = PH_AFTER_ROOT;
            end
          end
        end
        PH_AFTER_ROOT: begin
          if (c == CH_SLASH) begin
            phase_nxt = PH_NAME;
          end else begin
            rej_nxt = 1'b1;
          end
        end
        PH_NAME: begin
          if (c == CH_SLASH) begin
            if ((name_pos_r != 4'd0) && name_done) begin
              phase_nxt    = PH_SEGMENT;
              seg_len_nxt  = '0;
              seg_dots_nxt = 1'b1;
            end else begin
              rej_nxt = 1'b1;
            end
          end else begin
            cand_nxt = cand_r & char_hit;
            if (name_pos_r != 4'hF) begin
              name_pos_nxt = name_pos_r + 4'd1;
            end
            if ((cand_r & char_hit) == '0) begin
              rej_nxt = 1'b1;
            end
          end
        end
        PH_SEGMENT: begin
          if ((c == CH_BSL) || (c == CH_COLON) || (c < CH_SPACE)) begin
            rej_nxt = 1'b1;
          end else if (c == CH_SLASH) begin
            if ((seg_len_r == 2'd0) || dot_seg) begin
              rej_nxt = 1'b1;
            end else begin
              seg_len_nxt  = '0;
              seg_dots_nxt = 1'b1;
            end
          end else begin
            if (seg_len_r != 2'd3) begin
              seg_len_nxt = seg_len_r + 2'd1;
            end
            if (c != CH_DOT) begin
              seg_dots_nxt = 1'b0;
            end
          end
        end
        default: rej_nxt = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_ROOT;
      prefix_pos_r <= '0;
      cand_r       <= '1;
      name_pos_r   <= '0;
      seg_len_r    <= '0;
      seg_dots_r   <= 1'b1;
      rej_r        <= 1'b0;
    end else if (step.fire) begin
      phase_r      <= phase_nxt;
      prefix_pos_r <= prefix_pos_nxt;
      cand_r       <= cand_nxt;
      name_pos_r   <= name_pos_nxt;
      seg_len_r    <= seg_len_nxt;
      seg_dots_r   <= seg_dots_nxt;
      rej_r        <= rej_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/managed_path_validator_top.sv
// Managed path validator. Takes one path byte per transfer and answers with one
// verdict transfer for each zero byte, which ends the path; non-zero bytes give no
// transfer. A byte can be taken every cycle while input is not stalled: it is held in
// the input register, checked by the combinational logic in mpv_core, and a verdict
// lands in the output register. The block stalls input only while a zero byte waits
// for a full output register that is not being drained.
// depends on mpv_pkg and mpv_core
`default_nettype none

module managed_path_validator_top
  import mpv_pkg::*;
#(
  parameter int unsigned NAME_COUNT = 7
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_path_char,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_accepted
);

  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_char_r;
  logic       out_vld_r, out_vld_nxt;
  logic       out_acc_r;
  logic       is_end;
  logic       fire;
  logic       verdict;
  mpv_step_t  step;

  assign is_end   = (in_char_r == CH_NUL);
  assign fire     = in_vld_r && (!is_end || !out_vld_r || out_ready);
  assign in_ready = !in_vld_r || fire;

  assign step.fire = fire;
  assign step.code = in_char_r;

  mpv_core #(
    .NAME_COUNT(NAME_COUNT)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .verdict (verdict)
  );

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_ready) begin
      in_vld_nxt = in_valid;
    end
    out_vld_nxt = out_vld_r && !out_ready;
    if (fire && is_end) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_char_r <= in_path_char;
    end
    if (fire && is_end) begin
      out_acc_r <= verdict;
    end
  end

  assign out_valid    = out_vld_r;
  assign out_accepted = out_acc_r;

endmodule

`default_nettype wire
